// File: src/bft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bft_pkg
// Shared types, sizes and codes of the bidirectional flow tracker.
// ----------------------------------------------------------------------------
package bft_pkg;

  localparam int BUCKET_COUNT = 1024;
  localparam int FLOW_ENTRIES = 256;
  localparam int BKT_W        = $clog2(BUCKET_COUNT);
  localparam int SLOT_W       = $clog2(FLOW_ENTRIES);
  localparam int LINK_W       = SLOT_W + 1;
  localparam logic [LINK_W-1:0] LINK_NIL = LINK_W'(FLOW_ENTRIES);
  localparam logic [BKT_W-1:0]  BKT_LAST = BKT_W'(BUCKET_COUNT - 1);

  localparam int TMO_W = 23;
  localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(300);
  localparam int USEC_W = 20;
  localparam logic [USEC_W-1:0] US_PER_SEC = USEC_W'(1000000);
  localparam int THR_W = TMO_W + USEC_W;

  localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
  localparam logic [31:0] PKT_MAX  = 32'hFFFF_FFFF;
  localparam logic [47:0] BYTE_MAX = 48'hFFFF_FFFF_FFFF;

  localparam int FREE_GRP    = 16;
  localparam int FREE_GROUPS = FLOW_ENTRIES / FREE_GRP;
  localparam int SUB_W       = $clog2(FREE_GRP);

  localparam logic [2:0] ST_EXIST = 3'd0;
  localparam logic [2:0] ST_NEW   = 3'd1;
  localparam logic [2:0] ST_DROP  = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_SWEEP = 3'd4;

  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_SWEEP  = 1'b1;

  typedef struct packed {
    logic        command;
    logic        header_ok;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  ip_protocol;
    logic [15:0] packet_bytes;
    logic [62:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             direction;
    logic [7:0]       entry_index;
    logic [31:0]      fwd_packets;
    logic [31:0]      rev_packets;
    logic [47:0]      fwd_bytes;
    logic [47:0]      rev_bytes;
    logic [CNT_W-1:0] active_flows;
    logic [CNT_W-1:0] expired_count;
  } out_item_t;

  typedef struct packed {
    logic [63:0] addrs;
    logic [39:0] ppp;
    logic [62:0] last;
    logic [31:0] pf;
    logic [31:0] pr;
    logic [47:0] bf;
    logic [47:0] br;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// File: src/bft_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bft_ifs
// Valid/ready channels of the flow tracker: items in, results out, config.
// ----------------------------------------------------------------------------
interface bft_in_if import bft_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bft_out_if import bft_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bft_cfg_if import bft_pkg::*;;
  logic             valid;
  logic             ready;
  logic [TMO_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/bft_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bft_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/bft_free_find.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bft_free_find
// Lowest free slot search as a registered two-level tree.
// ----------------------------------------------------------------------------
module bft_free_find import bft_pkg::*; (
  input  wire logic                    clk,
  input  wire logic [FLOW_ENTRIES-1:0] in_use,
  output logic                         found,
  output logic [SLOT_W-1:0]            index
);

  logic [FREE_GROUPS-1:0] grp_any;
  logic [SUB_W-1:0]       grp_first [FREE_GROUPS];

  always_ff @(posedge clk) begin
    for (int g = 0; g < FREE_GROUPS; g++) begin
      grp_any[g]   <= ~&in_use[g*FREE_GRP +: FREE_GRP];
      grp_first[g] <= '0;
      for (int k = FREE_GRP - 1; k >= 0; k--) begin
        if (!in_use[g*FREE_GRP + k]) begin
          grp_first[g] <= SUB_W'(k);
        end
      end
    end
  end

  always_comb begin
    found = |grp_any;
    index = '0;
    for (int g = FREE_GROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        index = {(SLOT_W - SUB_W)'(g), grp_first[g]};
      end
    end
  end

endmodule

`default_nettype wire

// File: src/bidirectional_flow_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bidirectional_flow_tracker
// Five-tuple connection table with hashed bucket chains in RAM.
//
// in_ch carries packet and sweep items, out_ch returns one result per item,
// cfg_ch writes the idle timeout in seconds (always ready; write it only
// while the block is idle). After reset a clearing pass writes each of the
// 1024 bucket heads once to empty the bucket head RAM; no item is taken until
// it ends. A dropped packet goes from idle straight to the emit state.
// A packet walks the forward bucket chain and, if no entry there matches,
// the reverse chain, one entry per cycle through the registered read of the
// entry RAM. A sweep reads every bucket head and every stored flow once.
// Only one item is worked on at a time. The result waits in an output
// register; a new item is accepted while it waits, and an item that
// finishes before it is taken holds until the register frees.
// ----------------------------------------------------------------------------
module bidirectional_flow_tracker import bft_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  bft_in_if.sink     in_ch,
  bft_out_if.source  out_ch,
  bft_cfg_if.sink    cfg_ch
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FHEAD = 4'd2;
  localparam logic [3:0] S_FWALK = 4'd3;
  localparam logic [3:0] S_RHEAD = 4'd4;
  localparam logic [3:0] S_RWALK = 4'd5;
  localparam logic [3:0] S_ALLOC = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_SHEAD = 4'd8;
  localparam logic [3:0] S_SWALK = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0]              st, st_next;
  in_item_t                item, item_next;
  logic [BKT_W-1:0]        fb, fb_next, rb, rb_next, bkt, bkt_next;
  logic [LINK_W-1:0]       fhead, fhead_next, cur, cur_next, prev, prev_next;
  logic                    dir, dir_next;
  out_item_t               res, res_next, out_q, out_q_next;
  logic                    out_v, out_v_next;
  logic [CNT_W-1:0]        freed, freed_next, flow_count, flow_count_next;
  logic [FLOW_ENTRIES-1:0] in_use, in_use_next;
  logic [TMO_W-1:0]        timeout;
  logic [THR_W-1:0]        thr, thr_next;

  logic                    hd_we, hd_re;
  logic [BKT_W-1:0]        hd_waddr, hd_raddr;
  logic [LINK_W-1:0]       hd_wdata, hd_rdata;
  logic                    nx_we, nx_re;
  logic [SLOT_W-1:0]       nx_waddr, nx_raddr;
  logic [LINK_W-1:0]       nx_wdata, nx_rdata;
  logic                    en_we;
  logic [SLOT_W-1:0]       en_waddr;
  logic [ENTRY_W-1:0]      en_wdata, en_rdata;
  entry_t                  ent, ent_new;
  logic                    ff_found;
  logic [SLOT_W-1:0]       ff_idx;

  bft_ram #(.WIDTH(LINK_W), .DEPTH(BUCKET_COUNT)) u_head (
    .clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
    .re(hd_re), .raddr(hd_raddr), .rdata(hd_rdata)
  );

  bft_ram #(.WIDTH(LINK_W), .DEPTH(FLOW_ENTRIES)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .re(nx_re), .raddr(nx_raddr), .rdata(nx_rdata)
  );

  bft_ram #(.WIDTH(ENTRY_W), .DEPTH(FLOW_ENTRIES)) u_entry (
    .clk(clk), .we(en_we), .waddr(en_waddr), .wdata(en_wdata),
    .re(nx_re), .raddr(nx_raddr), .rdata(en_rdata)
  );

  bft_free_find u_free (
    .clk(clk), .in_use(in_use), .found(ff_found), .index(ff_idx)
  );

  function automatic logic [BKT_W-1:0] bucket_of(input logic [31:0] a,
                                                 input logic [31:0] b,
                                                 input logic [15:0] pa,
                                                 input logic [15:0] pb,
                                                 input logic [7:0]  pr);
    logic [31:0] h;
    h = a ^ b ^ {pa, pb} ^ {24'd0, pr};
    return h[BKT_W-1:0];
  endfunction

  assign in_ch.ready  = (st == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_v;
  assign out_ch.data  = out_q;
  assign ent          = entry_t'(en_rdata);

  always_comb begin
    logic        fwd_hit, rev_hit, idle, out_free, walk_next, bkt_done;
    logic [62:0] age;
    logic [48:0] bsum;
    st_next         = st;
    item_next       = item;
    fb_next         = fb;
    rb_next         = rb;
    bkt_next        = bkt;
    fhead_next      = fhead;
    cur_next        = cur;
    prev_next       = prev;
    dir_next        = dir;
    res_next        = res;
    out_q_next      = out_q;
    out_v_next      = out_v;
    freed_next      = freed;
    flow_count_next = flow_count;
    in_use_next     = in_use;
    thr_next        = thr;
    hd_we = 1'b0; hd_waddr = bkt; hd_wdata = LINK_NIL;
    hd_re = 1'b0; hd_raddr = fb;
    nx_we = 1'b0; nx_waddr = '0; nx_wdata = LINK_NIL;
    nx_re = 1'b0; nx_raddr = '0;
    en_we = 1'b0; en_waddr = cur[SLOT_W-1:0];
    ent_new = ent;
    fwd_hit = (ent.addrs == {item.source_address, item.dest_address}) &&
              (ent.ppp == {item.source_port, item.dest_port, item.ip_protocol});
    rev_hit = (ent.addrs == {item.dest_address, item.source_address}) &&
              (ent.ppp == {item.dest_port, item.source_port, item.ip_protocol});
    age  = item.now_us - ent.last;
    idle = (timeout != '0) && (item.now_us > ent.last) && (age > 63'(thr));
    bsum = '0;
    out_free  = !out_v || out_ch.ready;
    walk_next = 1'b0;
    bkt_done  = 1'b0;

    if (out_v && out_ch.ready) begin
      out_v_next = 1'b0;
    end

    case (st)
      S_CLR: begin
        hd_we    = 1'b1;
        bkt_next = bkt + 1'b1;
        if (bkt == BKT_LAST) begin
          st_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          item_next  = in_ch.data;
          freed_next = '0;
          res_next   = '0;
          if (in_ch.data.command == CMD_SWEEP) begin
            thr_next = THR_W'(timeout) * THR_W'(US_PER_SEC);
            bkt_next = '0;
            hd_re    = 1'b1;
            hd_raddr = '0;
            st_next  = S_SHEAD;
          end else if (!in_ch.data.header_ok) begin
            res_next.status = ST_DROP;
            st_next = S_EMIT;
          end else begin
            fb_next = bucket_of(in_ch.data.source_address, in_ch.data.dest_address,
                                in_ch.data.source_port, in_ch.data.dest_port,
                                in_ch.data.ip_protocol);
            rb_next = bucket_of(in_ch.data.dest_address, in_ch.data.source_address,
                                in_ch.data.dest_port, in_ch.data.source_port,
                                in_ch.data.ip_protocol);
            hd_re    = 1'b1;
            hd_raddr = fb_next;
            st_next  = S_FHEAD;
          end
        end
      end
      S_FHEAD, S_RHEAD: begin
        if (st == S_FHEAD) begin
          fhead_next = hd_rdata;
        end
        if (hd_rdata == LINK_NIL) begin
          if (st == S_FHEAD) begin
            hd_re    = 1'b1;
            hd_raddr = rb;
            st_next  = S_RHEAD;
          end else begin
            st_next = S_ALLOC;
          end
        end else begin
          nx_re    = 1'b1;
          nx_raddr = hd_rdata[SLOT_W-1:0];
          cur_next = hd_rdata;
          st_next  = (st == S_FHEAD) ? S_FWALK : S_RWALK;
        end
      end
      S_FWALK, S_RWALK: begin
        if ((st == S_FWALK) ? fwd_hit : rev_hit) begin
          dir_next = (st == S_RWALK);
          st_next  = S_UPD;
        end else if (nx_rdata == LINK_NIL) begin
          if (st == S_FWALK) begin
            hd_re    = 1'b1;
            hd_raddr = rb;
            st_next  = S_RHEAD;
          end else begin
            st_next = S_ALLOC;
          end
        end else begin
          nx_re    = 1'b1;
          nx_raddr = nx_rdata[SLOT_W-1:0];
          cur_next = nx_rdata;
        end
      end
      S_ALLOC: begin
        res_next = '0;
        if (!ff_found) begin
          res_next.status = ST_FULL;
        end else begin
          ent_new.addrs = {item.source_address, item.dest_address};
          ent_new.ppp   = {item.source_port, item.dest_port, item.ip_protocol};
          ent_new.last  = item.now_us;
          ent_new.pf    = 32'd1;
          ent_new.pr    = '0;
          ent_new.bf    = 48'(item.packet_bytes);
          ent_new.br    = '0;
          en_we    = 1'b1;
          en_waddr = ff_idx;
          nx_we    = 1'b1;
          nx_waddr = ff_idx;
          nx_wdata = fhead;
          hd_we    = 1'b1;
          hd_waddr = fb;
          hd_wdata = {1'b0, ff_idx};
          in_use_next[ff_idx] = 1'b1;
          flow_count_next     = flow_count + 1'b1;
          res_next.status      = ST_NEW;
          res_next.entry_index = 8'(ff_idx);
          res_next.fwd_packets = ent_new.pf;
          res_next.fwd_bytes   = ent_new.bf;
        end
        st_next = S_EMIT;
      end
      S_UPD: begin
        ent_new.last = item.now_us;
        if (!dir) begin
          ent_new.pf = (ent.pf == PKT_MAX) ? PKT_MAX : ent.pf + 32'd1;
          bsum       = {1'b0, ent.bf} + 49'(item.packet_bytes);
          ent_new.bf = bsum[48] ? BYTE_MAX : bsum[47:0];
        end else begin
          ent_new.pr = (ent.pr == PKT_MAX) ? PKT_MAX : ent.pr + 32'd1;
          bsum       = {1'b0, ent.br} + 49'(item.packet_bytes);
          ent_new.br = bsum[48] ? BYTE_MAX : bsum[47:0];
        end
        en_we = 1'b1;
        res_next.status      = ST_EXIST;
        res_next.direction   = dir;
        res_next.entry_index = 8'(cur[SLOT_W-1:0]);
        res_next.fwd_packets = ent_new.pf;
        res_next.rev_packets = ent_new.pr;
        res_next.fwd_bytes   = ent_new.bf;
        res_next.rev_bytes   = ent_new.br;
        st_next = S_EMIT;
      end
      S_SHEAD: begin
        prev_next = LINK_NIL;
        if (hd_rdata == LINK_NIL) begin
          bkt_done = 1'b1;
        end else begin
          walk_next = 1'b1;
          cur_next  = hd_rdata;
        end
      end
      S_SWALK: begin
        if (idle) begin
          if (prev == LINK_NIL) begin
            hd_we    = 1'b1;
            hd_waddr = bkt;
            hd_wdata = nx_rdata;
          end else begin
            nx_we    = 1'b1;
            nx_waddr = prev[SLOT_W-1:0];
            nx_wdata = nx_rdata;
          end
          in_use_next[cur[SLOT_W-1:0]] = 1'b0;
          if (flow_count != '0) begin
            flow_count_next = flow_count - 1'b1;
          end
          freed_next = freed + 1'b1;
        end else begin
          prev_next = cur;
        end
        cur_next = nx_rdata;
        if (nx_rdata == LINK_NIL) begin
          bkt_done = 1'b1;
        end else begin
          walk_next = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_q_next               = res;
          out_q_next.active_flows  = flow_count;
          out_q_next.expired_count = freed;
          out_v_next               = 1'b1;
          st_next                  = S_IDLE;
        end
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase

    if (walk_next) begin
      nx_re    = 1'b1;
      nx_raddr = cur_next[SLOT_W-1:0];
      st_next  = S_SWALK;
    end
    if (bkt_done) begin
      if (bkt == BKT_LAST) begin
        res_next        = '0;
        res_next.status = ST_SWEEP;
        st_next         = S_EMIT;
      end else begin
        bkt_next  = bkt + 1'b1;
        hd_re     = 1'b1;
        hd_raddr  = bkt + 1'b1;
        prev_next = LINK_NIL;
        st_next   = S_SHEAD;
      end
    end
  end

  assign en_wdata = ENTRY_W'(ent_new);

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_CLR;
      bkt        <= '0;
      out_v      <= 1'b0;
      flow_count <= '0;
      in_use     <= '0;
      timeout    <= TMO_RESET;
      freed      <= '0;
    end else begin
      st         <= st_next;
      bkt        <= bkt_next;
      out_v      <= out_v_next;
      flow_count <= flow_count_next;
      in_use     <= in_use_next;
      freed      <= freed_next;
      if (cfg_ch.valid) begin
        timeout <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    item  <= item_next;
    fb    <= fb_next;
    rb    <= rb_next;
    fhead <= fhead_next;
    cur   <= cur_next;
    prev  <= prev_next;
    dir   <= dir_next;
    res   <= res_next;
    out_q <= out_q_next;
    thr   <= thr_next;
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    32'(flow_count) == $countones(in_use))
    else $error("flow count disagrees with the slots in use");

  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    (st == S_ALLOC && ff_found) |-> !in_use[ff_idx])
    else $error("allocation picked a slot already in use");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (st == S_EMIT && (!out_v || out_ch.ready)) |=> (out_v && st == S_IDLE))
    else $error("finished item did not reach the output register");

  a_new_counts: assert property (@(posedge clk) disable iff (rst)
    (out_v && out_q.status == ST_NEW) |-> (out_q.active_flows != '0))
    else $error("new flow reported with an empty table");

endmodule

`default_nettype wire
